@@ sv/rcs_pkg.sv @@
// Shared constants, types and helper functions of the streaming 3x3 RGB filter.
package rcs_pkg;

   // Line store depth; sets the widest frame the block can filter.
   localparam int MAX_WIDTH  = 512;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int EW_W       = $clog2(MAX_WIDTH + 1);
   localparam int WREG_W     = 10;
   localparam int HREG_W     = 12;
   localparam int CMP_W      = (EW_W > WREG_W) ? EW_W : WREG_W;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 9;
   localparam int MIN_WIDTH  = 3;
   localparam int MIN_HEIGHT = 2;

   localparam int NUM_CH     = 3;
   localparam int CH_W       = 8;
   localparam int PIX_W      = NUM_CH * CH_W;
   localparam int COEF_W     = 16;
   localparam int NUM_TAPS   = 3;
   localparam int CROW_W     = NUM_TAPS * COEF_W;
   localparam int FRAC_W     = 8;

   // signed Q8.8 coefficient times unsigned 8-bit channel
   localparam int PROD_W     = COEF_W + CH_W;
   localparam int PRODX_W    = PROD_W + 1;
   localparam int ROWSUM_W   = PROD_W + 2;
   localparam int SUM_W      = PROD_W + 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CROW_W;

   localparam logic [WREG_W-1:0] WIDTH_RST    = WREG_W'(512);
   localparam logic [HREG_W-1:0] HEIGHT_RST   = HREG_W'(512);
   localparam logic [CROW_W-1:0] COEF_TOP_RST = 48'h0100_0000_FF00;
   localparam logic [CROW_W-1:0] COEF_MID_RST = 48'h0200_0000_FE00;
   localparam logic [CROW_W-1:0] COEF_BOT_RST = 48'h0100_0000_FF00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_COEF_TOP     = 3'd2,
      CSR_COEF_MID     = 3'd3,
      CSR_COEF_BOTTOM  = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef logic [PIX_W-1:0]           pixel_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ROWSUM_W-1:0] rowsum_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef struct packed {
      logic push;      // shift a new pixel into the taps
      logic advance;   // move the arithmetic stages
      logic row_ok;    // window row lies inside the frame
      logic left_ok;
      logic right_ok;
   } cell_ctl_type;

   typedef struct packed {
      logic [CH_W-1:0]      blue;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      red;
      logic [OUT_COL_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } rsp_type;

   function automatic rowsum_type widen_prod(prod_type p);
      return {{(ROWSUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   function automatic sum_type widen_row(rowsum_type r);
      return {{(SUM_W - ROWSUM_W){r[ROWSUM_W-1]}}, r};
   endfunction

   // Non-positive sums give 0; otherwise drop the fraction and cap at 255.
   function automatic logic [CH_W-1:0] clamp_sum(sum_type s);
      logic [CH_W-1:0] v;
      if (s[SUM_W-1] || (s == '0)) begin
         v = '0;
      end else if (|s[SUM_W-1:FRAC_W+CH_W]) begin
         v = '1;
      end else begin
         v = s[FRAC_W+CH_W-1:FRAC_W];
      end
      return v;
   endfunction

endpackage

@@ sv/rcs_if.sv @@
// Stream and register-write channel interfaces of the 3x3 RGB filter.
interface rcs_req_if;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [rcs_pkg::CH_W-1:0] blue_in;
   logic [rcs_pkg::CH_W-1:0] green_in;
   logic [rcs_pkg::CH_W-1:0] red_in;

   modport source (output valid, op, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, op, blue_in, green_in, red_in, output ready);
endinterface

interface rcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcs_pkg::CH_W-1:0]      blue_out;
   logic [rcs_pkg::CH_W-1:0]      green_out;
   logic [rcs_pkg::CH_W-1:0]      red_out;
   logic [rcs_pkg::OUT_COL_W-1:0] out_col;
   logic [rcs_pkg::ROW_W-1:0]     out_row;
   logic                          frame_last;

   modport source (output valid, blue_out, green_out, red_out, out_col, out_row,
                   frame_last, input ready);
   modport sink   (input valid, blue_out, green_out, red_out, out_col, out_row,
                   frame_last, output ready);
endinterface

interface rcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rcs_pkg::CSR_IDX_W-1:0]  index;
   logic [rcs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/rgb_conv3x3_stream.sv @@
// Top level of the streaming 3x3 RGB filter: control counters, line delays, row cells, output.
// Streaming 3x3 convolution of BGR pixels in raster order, zero padding at the frame edges,
// one signed Q8.8 kernel applied to all three channels, each channel truncated and clamped
// to 0..255. The block takes one item per clock unless the result side stalls: each pixel
// or draining flush shifts the pixel chain (two line memories, one write and one read each
// per cycle, and three window-row cells). The result for a pixel passes the product,
// row-sum and output registers after the transfer that completes its window, i.e. the pixel
// one line plus one column later. After the last pixel of a frame, image_width+1 flush
// items (op=1) drain the remaining results; frame_last marks the final one. A pixel that
// arrives while a frame is still draining starts a new frame and drops what was pending.
// Writing image_width or image_height restarts the frame; coefficient writes apply to the
// next result. Registers are to be written only while the stream is idle; not enforced.
module rgb_conv3x3_stream (
   input logic       clock,
   input logic       reset,
   rcs_req_if.sink   req_ch,
   rcs_rsp_if.source rsp_ch,
   rcs_csr_if.sink   csr_ch
);

   // configuration
   logic [rcs_pkg::WREG_W-1:0] width_ff;
   logic [rcs_pkg::HREG_W-1:0] height_ff;
   logic [rcs_pkg::CROW_W-1:0] coef_top_ff;
   logic [rcs_pkg::CROW_W-1:0] coef_mid_ff;
   logic [rcs_pkg::CROW_W-1:0] coef_bot_ff;
   logic                       csr_write;
   logic                       csr_restart;

   logic [rcs_pkg::CMP_W-1:0]  w_cmp;
   logic [rcs_pkg::EW_W-1:0]   w_eff;
   logic [rcs_pkg::ROW_W-1:0]  h_eff;

   // position counters
   logic [rcs_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [rcs_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [rcs_pkg::COL_W-1:0] wr_col_ff, wr_col_in;
   logic [rcs_pkg::COL_W-1:0] ecol_ff, ecol_in;
   logic [rcs_pkg::ROW_W-1:0] erow_ff, erow_in;

   logic                      pipe_en;
   logic                      accept;
   logic                      is_pixel;
   logic                      pix_restart;
   logic                      flush_emit;
   logic                      pix_emit;
   logic                      push;
   logic                      emit;
   logic                      e_last;
   logic [rcs_pkg::COL_W-1:0] cur_col;
   logic [rcs_pkg::ROW_W-1:0] cur_row;
   logic [rcs_pkg::COL_W-1:0] cur_ecol;
   logic [rcs_pkg::ROW_W-1:0] cur_erow;
   logic [rcs_pkg::COL_W-1:0] addr;
   logic [rcs_pkg::COL_W-1:0] nxt_addr;
   rcs_pkg::pixel_type        new_px;

   // pipeline side band
   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [rcs_pkg::COL_W-1:0]    s1_col_ff, s2_col_ff, s3_col_ff;
   logic [rcs_pkg::ROW_W-1:0]    s1_row_ff, s2_row_ff, s3_row_ff;
   logic                         s1_last_ff, s2_last_ff, s3_last_ff;
   logic                         s1_top_ok_ff, s1_bot_ok_ff, s1_left_ok_ff, s1_right_ok_ff;

   rcs_pkg::pixel_type        line_a_px;
   rcs_pkg::pixel_type        line_b_px;
   rcs_pkg::cell_ctl_type     ctl_top, ctl_mid, ctl_bot;
   rcs_pkg::rowsum_type       sum_top [rcs_pkg::NUM_CH];
   rcs_pkg::rowsum_type       sum_mid [rcs_pkg::NUM_CH];
   rcs_pkg::rowsum_type       sum_bot [rcs_pkg::NUM_CH];
   rcs_pkg::sum_type          sum_in  [rcs_pkg::NUM_CH];

   // output register and skid stage
   rcs_pkg::rsp_type res_in;
   rcs_pkg::rsp_type rsp_data_ff;
   rcs_pkg::rsp_type skid_data_ff;
   logic             rsp_valid_ff;
   logic             skid_valid_ff;
   logic             out_free;
   logic             deliver;

   // ---------------------------------------------------------------- config
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;
   assign csr_restart  = csr_write &&
                         ((csr_ch.index == rcs_pkg::CSR_IMAGE_WIDTH) ||
                          (csr_ch.index == rcs_pkg::CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rcs_pkg::WIDTH_RST;
         height_ff   <= rcs_pkg::HEIGHT_RST;
         coef_top_ff <= rcs_pkg::COEF_TOP_RST;
         coef_mid_ff <= rcs_pkg::COEF_MID_RST;
         coef_bot_ff <= rcs_pkg::COEF_BOT_RST;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            rcs_pkg::CSR_IMAGE_WIDTH:  width_ff    <= csr_ch.data[rcs_pkg::WREG_W-1:0];
            rcs_pkg::CSR_IMAGE_HEIGHT: height_ff   <= csr_ch.data[rcs_pkg::HREG_W-1:0];
            rcs_pkg::CSR_COEF_TOP:     coef_top_ff <= csr_ch.data;
            rcs_pkg::CSR_COEF_MID:     coef_mid_ff <= csr_ch.data;
            rcs_pkg::CSR_COEF_BOTTOM:  coef_bot_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_cmp = rcs_pkg::CMP_W'(width_ff);
      priority if (w_cmp < rcs_pkg::CMP_W'(rcs_pkg::MIN_WIDTH)) begin
         w_eff = rcs_pkg::EW_W'(rcs_pkg::MIN_WIDTH);
      end else if (w_cmp > rcs_pkg::CMP_W'(rcs_pkg::MAX_WIDTH)) begin
         w_eff = rcs_pkg::EW_W'(rcs_pkg::MAX_WIDTH);
      end else begin
         w_eff = rcs_pkg::EW_W'(w_cmp);
      end
      h_eff = (height_ff < rcs_pkg::HREG_W'(rcs_pkg::MIN_HEIGHT)) ?
              rcs_pkg::HREG_W'(rcs_pkg::MIN_HEIGHT) : height_ff;
   end

   // ---------------------------------------------------------------- control
   assign pipe_en      = !skid_valid_ff;
   assign req_ch.ready = pipe_en;
   assign accept       = req_ch.valid && pipe_en;

   always_comb begin
      is_pixel    = (req_ch.op == rcs_pkg::OP_PIXEL);
      // a pixel after the last input line begins a fresh frame
      pix_restart = is_pixel && (in_row_ff >= h_eff);
      cur_col     = pix_restart ? '0 : in_col_ff;
      cur_row     = pix_restart ? '0 : in_row_ff;
      cur_ecol    = pix_restart ? '0 : ecol_ff;
      cur_erow    = pix_restart ? '0 : erow_ff;

      // the window is complete once one line plus two pixels are in
      pix_emit   = (cur_row >= rcs_pkg::ROW_W'(2)) ||
                   ((cur_row == rcs_pkg::ROW_W'(1)) && (cur_col != '0));
      flush_emit = !is_pixel && (in_row_ff >= h_eff) && (erow_ff < h_eff);
      push       = accept && (is_pixel || flush_emit);
      emit       = accept && (is_pixel ? pix_emit : flush_emit);
      e_last     = ((cur_erow + rcs_pkg::ROW_W'(1)) == h_eff) &&
                   ((rcs_pkg::EW_W'(cur_ecol) + rcs_pkg::EW_W'(1)) == w_eff);

      addr     = pix_restart ? '0 : wr_col_ff;
      nxt_addr = ((rcs_pkg::EW_W'(addr) + rcs_pkg::EW_W'(1)) == w_eff) ?
                 '0 : addr + rcs_pkg::COL_W'(1);
      new_px   = is_pixel ? {req_ch.red_in, req_ch.green_in, req_ch.blue_in} : '0;

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      wr_col_in = wr_col_ff;
      ecol_in   = ecol_ff;
      erow_in   = erow_ff;
      if (csr_restart) begin
         in_col_in = '0;
         in_row_in = '0;
         wr_col_in = '0;
         ecol_in   = '0;
         erow_in   = '0;
      end else if (push) begin
         wr_col_in = nxt_addr;
         ecol_in   = cur_ecol;
         erow_in   = cur_erow;
         if (is_pixel) begin
            if ((rcs_pkg::EW_W'(cur_col) + rcs_pkg::EW_W'(1)) == w_eff) begin
               in_col_in = '0;
               in_row_in = cur_row + rcs_pkg::ROW_W'(1);
            end else begin
               in_col_in = cur_col + rcs_pkg::COL_W'(1);
               in_row_in = cur_row;
            end
         end
         if (emit) begin
            if ((rcs_pkg::EW_W'(cur_ecol) + rcs_pkg::EW_W'(1)) == w_eff) begin
               ecol_in = '0;
               erow_in = cur_erow + rcs_pkg::ROW_W'(1);
            end else begin
               ecol_in = cur_ecol + rcs_pkg::COL_W'(1);
            end
         end
         // last result drained: ready for the next frame
         if (flush_emit && e_last) begin
            in_col_in = '0;
            in_row_in = '0;
            wr_col_in = '0;
            ecol_in   = '0;
            erow_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         wr_col_ff <= '0;
         ecol_ff   <= '0;
         erow_ff   <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         wr_col_ff <= wr_col_in;
         ecol_ff   <= ecol_in;
         erow_ff   <= erow_in;
      end
   end

   // ---------------------------------------------------------------- side band
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= emit;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_col_ff      <= cur_ecol;
         s1_row_ff      <= cur_erow;
         s1_last_ff     <= e_last;
         s1_top_ok_ff   <= (cur_erow != '0);
         s1_bot_ok_ff   <= ((cur_erow + rcs_pkg::ROW_W'(1)) < h_eff);
         s1_left_ok_ff  <= (cur_ecol != '0);
         s1_right_ok_ff <= ((rcs_pkg::EW_W'(cur_ecol) + rcs_pkg::EW_W'(1)) < w_eff);
         s2_col_ff      <= s1_col_ff;
         s2_row_ff      <= s1_row_ff;
         s2_last_ff     <= s1_last_ff;
         s3_col_ff      <= s2_col_ff;
         s3_row_ff      <= s2_row_ff;
         s3_last_ff     <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------- pixel chain
   rcs_line_delay u_line_a (
      .clock   (clock),
      .push    (push),
      .wr_addr (addr),
      .rd_addr (nxt_addr),
      .wr_data (new_px),
      .rd_data (line_a_px)
   );

   rcs_line_delay u_line_b (
      .clock   (clock),
      .push    (push),
      .wr_addr (addr),
      .rd_addr (nxt_addr),
      .wr_data (line_a_px),
      .rd_data (line_b_px)
   );

   always_comb begin
      ctl_top.push     = push;
      ctl_top.advance  = pipe_en;
      ctl_top.row_ok   = s1_top_ok_ff;
      ctl_top.left_ok  = s1_left_ok_ff;
      ctl_top.right_ok = s1_right_ok_ff;
      ctl_mid          = ctl_top;
      ctl_mid.row_ok   = 1'b1;
      ctl_bot          = ctl_top;
      ctl_bot.row_ok   = s1_bot_ok_ff;
   end

   rcs_row_cell u_cell_top (
      .clock    (clock),
      .ctl      (ctl_top),
      .pix_in   (line_b_px),
      .coef_row (coef_top_ff),
      .row_sum  (sum_top)
   );

   rcs_row_cell u_cell_mid (
      .clock    (clock),
      .ctl      (ctl_mid),
      .pix_in   (line_a_px),
      .coef_row (coef_mid_ff),
      .row_sum  (sum_mid)
   );

   rcs_row_cell u_cell_bot (
      .clock    (clock),
      .ctl      (ctl_bot),
      .pix_in   (new_px),
      .coef_row (coef_bot_ff),
      .row_sum  (sum_bot)
   );

   // ---------------------------------------------------------------- output
   always_comb begin
      for (int c = 0; c < rcs_pkg::NUM_CH; c++) begin
         sum_in[c] = rcs_pkg::widen_row(sum_top[c]) + rcs_pkg::widen_row(sum_mid[c])
                   + rcs_pkg::widen_row(sum_bot[c]);
      end
      res_in.blue  = rcs_pkg::clamp_sum(sum_in[0]);
      res_in.green = rcs_pkg::clamp_sum(sum_in[1]);
      res_in.red   = rcs_pkg::clamp_sum(sum_in[2]);
      res_in.col   = rcs_pkg::OUT_COL_W'(s3_col_ff);
      res_in.row   = s3_row_ff;
      res_in.last  = s3_last_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign deliver  = pipe_en && s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || deliver;
         skid_valid_ff <= 1'b0;
      end else if (deliver) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : res_in;
      end
      if (!out_free && deliver) begin
         skid_data_ff <= res_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.blue_out   = rsp_data_ff.blue;
   assign rsp_ch.green_out  = rsp_data_ff.green;
   assign rsp_ch.red_out    = rsp_data_ff.red;
   assign rsp_ch.out_col    = rsp_data_ff.col;
   assign rsp_ch.out_row    = rsp_data_ff.row;
   assign rsp_ch.frame_last = rsp_data_ff.last;

endmodule

@@ sv/rcs_line_delay.sv @@
// One-line pixel delay: memory addressed by column, read data prefetched one push ahead.
module rcs_line_delay (
   input  logic                      clock,
   input  logic                      push,
   input  logic [rcs_pkg::COL_W-1:0] wr_addr,
   input  logic [rcs_pkg::COL_W-1:0] rd_addr,
   input  rcs_pkg::pixel_type        wr_data,
   output rcs_pkg::pixel_type        rd_data
);

   rcs_pkg::pixel_type mem [rcs_pkg::MAX_WIDTH];
   rcs_pkg::pixel_type rd_data_ff;

   // rd_addr is the column of the next push, so rd_data is ready when it arrives
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_addr] <= wr_data;
         rd_data_ff   <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rcs_row_cell.sv @@
// One window row: three pixel taps, masked products and the per-channel row sum.
module rcs_row_cell (
   input  logic                       clock,
   input  rcs_pkg::cell_ctl_type      ctl,
   input  rcs_pkg::pixel_type         pix_in,
   input  logic [rcs_pkg::CROW_W-1:0] coef_row,
   output rcs_pkg::rowsum_type        row_sum [rcs_pkg::NUM_CH]
);

   // tap 0 holds the newest pixel (right neighbor), tap 2 the oldest (left)
   rcs_pkg::pixel_type         tap_ff     [rcs_pkg::NUM_TAPS];
   rcs_pkg::pixel_type         win_px     [rcs_pkg::NUM_TAPS];
   logic                       tap_ok     [rcs_pkg::NUM_TAPS];
   logic signed [rcs_pkg::PRODX_W-1:0] coef_x [rcs_pkg::NUM_TAPS];
   logic signed [rcs_pkg::PRODX_W-1:0] chan_x [rcs_pkg::NUM_TAPS][rcs_pkg::NUM_CH];
   logic signed [rcs_pkg::PRODX_W-1:0] prod_x [rcs_pkg::NUM_TAPS][rcs_pkg::NUM_CH];
   rcs_pkg::prod_type          prod_in    [rcs_pkg::NUM_TAPS][rcs_pkg::NUM_CH];
   rcs_pkg::prod_type          prod_ff    [rcs_pkg::NUM_TAPS][rcs_pkg::NUM_CH];
   rcs_pkg::rowsum_type        row_sum_in [rcs_pkg::NUM_CH];
   rcs_pkg::rowsum_type        row_sum_ff [rcs_pkg::NUM_CH];

   always_comb begin
      tap_ok[0] = ctl.row_ok && ctl.left_ok;
      tap_ok[1] = ctl.row_ok;
      tap_ok[2] = ctl.row_ok && ctl.right_ok;
      for (int k = 0; k < rcs_pkg::NUM_TAPS; k++) begin
         win_px[k] = tap_ok[k] ? tap_ff[rcs_pkg::NUM_TAPS - 1 - k] : '0;
         coef_x[k] = {{(rcs_pkg::PRODX_W - rcs_pkg::COEF_W)
                       {coef_row[k*rcs_pkg::COEF_W + rcs_pkg::COEF_W - 1]}},
                      coef_row[k*rcs_pkg::COEF_W +: rcs_pkg::COEF_W]};
         for (int c = 0; c < rcs_pkg::NUM_CH; c++) begin
            chan_x[k][c] = {{(rcs_pkg::PRODX_W - rcs_pkg::CH_W){1'b0}},
                            win_px[k][c*rcs_pkg::CH_W +: rcs_pkg::CH_W]};
            prod_x[k][c]  = coef_x[k] * chan_x[k][c];
            prod_in[k][c] = prod_x[k][c][rcs_pkg::PROD_W-1:0];
         end
      end
      for (int c = 0; c < rcs_pkg::NUM_CH; c++) begin
         row_sum_in[c] = rcs_pkg::widen_prod(prod_ff[0][c])
                       + rcs_pkg::widen_prod(prod_ff[1][c])
                       + rcs_pkg::widen_prod(prod_ff[2][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         tap_ff[0] <= pix_in;
         tap_ff[1] <= tap_ff[0];
         tap_ff[2] <= tap_ff[1];
      end
      if (ctl.advance) begin
         prod_ff    <= prod_in;
         row_sum_ff <= row_sum_in;
      end
   end

   assign row_sum = row_sum_ff;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the streaming 3x3 RGB filter: scoreboard against a local predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcs_pkg::*;

   localparam int HIST_DEPTH    = 2 * MAX_WIDTH + 4;
   localparam int RANDOM_ITEMS  = 120;
   localparam int IDLE_PHASES   = 4;
   localparam int NOISE_PCT     = 5;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int unsigned LIMIT_CYCLES = 400000;

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;
   localparam logic [COEF_W-1:0] COEF_BOX = COEF_W'(28);   // about 1/9
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum int {
      K_RANDOM, K_SMALL, K_BOX, K_MAX, K_MIN, K_IDENTITY, K_SOBEL
   } kernel_kind_type;

   logic clock;
   logic reset;

   rcs_req_if req_ch ();
   rcs_rsp_if rsp_ch ();
   rcs_csr_if csr_ch ();

   rgb_conv3x3_stream DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [WREG_W-1:0] width_reg;
   logic [HREG_W-1:0] height_reg;
   logic [CROW_W-1:0] coef_rows [NUM_TAPS];
   pixel_type         pix_hist [HIST_DEPTH];
   int unsigned       in_col, in_row, emit_pos;
   rsp_type           filtered_q [$];

   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned random_items = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      emit_pos = 0;
   endfunction

   function automatic int unsigned frame_width();
      int unsigned v;
      v = width_reg;
      if (v < MIN_WIDTH) v = MIN_WIDTH;
      if (v > MAX_WIDTH) v = MAX_WIDTH;
      return v;
   endfunction

   function automatic int unsigned frame_height();
      int unsigned v;
      v = height_reg;
      if (v < MIN_HEIGHT) v = MIN_HEIGHT;
      return v;
   endfunction

   function automatic pixel_type window_tap(int y, int x, int w, int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return '0;
      return pix_hist[(y * w + x) % HIST_DEPTH];
   endfunction

   function automatic logic [CH_W-1:0] saturate_channel(longint s);
      if (s <= 0) return '0;
      if (s >= (longint'(1) << (FRAC_W + CH_W))) return '1;
      return s[FRAC_W +: CH_W];
   endfunction

   function automatic rsp_type window_result(int w, int h);
      rsp_type   r;
      int        row, col, j, i, c;
      longint    acc [NUM_CH];
      longint    coef, chan;
      pixel_type px;
      row = emit_pos / w;
      col = emit_pos % w;
      for (c = 0; c < NUM_CH; c++) acc[c] = 0;
      for (j = 0; j < NUM_TAPS; j++) begin
         for (i = 0; i < NUM_TAPS; i++) begin
            px = window_tap(row + j - 1, col + i - 1, w, h);
            coef = $signed(coef_rows[j][COEF_W*i +: COEF_W]);
            for (c = 0; c < NUM_CH; c++) begin
               chan = px[CH_W*c +: CH_W];
               acc[c] += coef * chan;
            end
         end
      end
      r.blue  = saturate_channel(acc[0]);
      r.green = saturate_channel(acc[1]);
      r.red   = saturate_channel(acc[2]);
      r.col   = col[OUT_COL_W-1:0];
      r.row   = row[ROW_W-1:0];
      r.last  = (emit_pos + 1 == w * h);
      emit_pos++;
      return r;
   endfunction

   function automatic void filter_item(op_type op, pixel_type px);
      int unsigned w, h, lin;
      rsp_type     r;
      w = frame_width();
      h = frame_height();
      if (op == OP_PIXEL) begin
         // a pixel after the last row starts a new frame, dropping what was pending
         if (in_row >= h) restart_frame();
         lin = in_row * w + in_col;
         pix_hist[lin % HIST_DEPTH] = px;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (lin + 1 >= w + 2 && emit_pos < w * h) begin
            r = window_result(w, h);
            filtered_q = {filtered_q, r};
         end
      end else if (in_row >= h && emit_pos < w * h) begin
         r = window_result(w, h);
         filtered_q = {filtered_q, r};
         if (emit_pos >= w * h) restart_frame();
      end
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = data[WREG_W-1:0];
            restart_frame();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = data[HREG_W-1:0];
            restart_frame();
         end
         CSR_COEF_TOP:    coef_rows[0] = data;
         CSR_COEF_MID:    coef_rows[1] = data;
         CSR_COEF_BOTTOM: coef_rows[2] = data;
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(rsp_type want, rsp_type got, bit none_waiting);
      mismatches++;
      if (mismatches > REPORT_LIMIT) return;
      if (none_waiting)
         $display("mismatch: unexpected pixel b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                  got.blue, got.green, got.red, got.col, got.row, got.last);
      else
         $display("mismatch: exp b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b,",
                  want.blue, want.green, want.red, want.col, want.row, want.last,
                  " got b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                  got.blue, got.green, got.red, got.col, got.row, got.last);
   endfunction

   // sample all three channels at the edge; results first, then new input
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         width_reg    = WIDTH_RST;
         height_reg   = HEIGHT_RST;
         coef_rows[0] = COEF_TOP_RST;
         coef_rows[1] = COEF_MID_RST;
         coef_rows[2] = COEF_BOT_RST;
         restart_frame();
         filtered_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.blue  = rsp_ch.blue_out;
            got.green = rsp_ch.green_out;
            got.red   = rsp_ch.red_out;
            got.col   = rsp_ch.out_col;
            got.row   = rsp_ch.out_row;
            got.last  = rsp_ch.frame_last;
            if (filtered_q.size() == 0) begin
               note_mismatch(got, got, 1'b1);
            end else begin
               want = filtered_q.pop_front();
               if (got.blue !== want.blue || got.green !== want.green ||
                   got.red !== want.red || got.col !== want.col ||
                   got.row !== want.row || got.last !== want.last)
                  note_mismatch(want, got, 1'b0);
            end
         end
         if (req_ch.valid && req_ch.ready)
            filter_item(op_type'(req_ch.op), {req_ch.red_in, req_ch.green_in, req_ch.blue_in});
         if (csr_ch.valid && csr_ch.ready)
            apply_csr(csr_ch.index, csr_ch.data);
      end
   end

   // result side: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic pixel_type rand_pixel();
      pixel_type p;
      int        c;
      p = pixel_type'($urandom);
      for (c = 0; c < NUM_CH; c++)
         if ($urandom_range(7) == 0) p[CH_W*c +: CH_W] = {CH_W{p[CH_W*c]}};
      return p;
   endfunction

   function automatic logic [CROW_W-1:0] make_coef_row(kernel_kind_type kind, int slot);
      logic [CROW_W-1:0] r;
      int                k;
      r = '0;
      case (kind)
         K_RANDOM: r = CROW_W'({$urandom, $urandom});
         K_SMALL:
            for (k = 0; k < NUM_TAPS; k++)
               r[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(1024)) - 512);
         K_BOX:    r = {NUM_TAPS{COEF_BOX}};
         K_MAX:    r = {NUM_TAPS{COEF_MAX}};
         K_MIN:    r = {NUM_TAPS{COEF_MIN}};
         K_IDENTITY: if (slot == 1) r[COEF_W +: COEF_W] = COEF_ONE;
         K_SOBEL:  r = (slot == 1) ? COEF_MID_RST : COEF_TOP_RST;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void set_idling(int phase);
      case (phase)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 62; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 62; end
         default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
   endfunction

   // leaves valid high; the next transfer or a drain lowers it
   task automatic send_item(op_type op, pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.blue_in  <= px[0*CH_W +: CH_W];
      req_ch.green_in <= px[1*CH_W +: CH_W];
      req_ch.red_in   <= px[2*CH_W +: CH_W];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   // upper data bits of the size registers carry junk; an unused index is hit too
   task automatic configure(int unsigned wreg, int unsigned hreg, kernel_kind_type kind);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'({$urandom, $urandom});
      write_csr(CSR_IDX_W'(CSR_COEF_BOTTOM) + CSR_IDX_W'($urandom_range(1, 3)), data);
      write_csr(CSR_COEF_TOP, make_coef_row(kind, 0));
      write_csr(CSR_COEF_MID, make_coef_row(kind, 1));
      write_csr(CSR_COEF_BOTTOM, make_coef_row(kind, 2));
      data = CSR_DATA_W'({$urandom, $urandom});
      data[WREG_W-1:0] = wreg[WREG_W-1:0];
      write_csr(CSR_IMAGE_WIDTH, data);
      data = CSR_DATA_W'({$urandom, $urandom});
      data[HREG_W-1:0] = hreg[HREG_W-1:0];
      write_csr(CSR_IMAGE_HEIGHT, data);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(int unsigned pixels, int unsigned flushes, int noise_pct);
      int unsigned n;
      for (n = 0; n < pixels; n++) begin
         if ($urandom_range(99) < noise_pct) send_item(OP_FLUSH, rand_pixel());
         send_item(OP_PIXEL, rand_pixel());
      end
      repeat (flushes) send_item(OP_FLUSH, rand_pixel());
   endtask

   // ---------------------------------------------------------------- tests

   // reset settings: full-width lines, Sobel kernel; partial frame only
   task automatic test_reset_state();
      send_frame(MAX_WIDTH + 3, 0, 0);
      wait_drained();
   endtask

   task automatic test_small_frames();
      pixel_type pat [6];
      int        i;
      pat = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00, 24'h0F0F0F, 24'hF0F0F0};
      // sizes below the minimum clamp to 3x2
      configure(MIN_WIDTH - 1, MIN_HEIGHT - 1, K_IDENTITY);
      send_item(OP_FLUSH, '0);                   // nothing pending yet
      for (i = 0; i < 6; i++) begin
         if (i == 3) send_item(OP_FLUSH, '1);    // frame still arriving
         send_item(OP_PIXEL, pat[i]);
      end
      repeat (MIN_WIDTH + 2) send_item(OP_FLUSH, '0);   // last one finds nothing
      wait_drained();

      configure(MIN_WIDTH, MIN_HEIGHT, K_MAX);
      for (i = 0; i < 6; i++) send_item(OP_PIXEL, ~pat[i]);
      repeat (2) send_item(OP_FLUSH, '0);
      // new frame while the old one still drains
      for (i = 0; i < 6; i++) send_item(OP_PIXEL, pat[5 - i]);
      repeat (MIN_WIDTH + 1) send_item(OP_FLUSH, '0);
      wait_drained();

      configure(MIN_WIDTH, MIN_HEIGHT, K_MIN);
      for (i = 0; i < 6; i++) send_item(OP_PIXEL, pat[i] ^ 24'h5A5A5A);
      repeat (MIN_WIDTH + 1) send_item(OP_FLUSH, '0);
      wait_drained();
   endtask

   // width register all ones clamps to the widest line; the next size write cuts the frame
   task automatic test_wide_frame();
      configure((1 << WREG_W) - 1, MIN_HEIGHT, K_SMALL);
      send_frame(MAX_WIDTH + 3, 0, 2);
      wait_drained();
   endtask

   // height register all ones; only the first lines go in before the next restart
   task automatic test_tall_frame();
      int unsigned tall;
      tall = (1 << HREG_W) - 1;
      configure(MIN_WIDTH, tall, K_BOX);
      send_frame(MIN_WIDTH * 8, 0, 0);
      wait_drained();
   endtask

   // result side held off while input keeps coming: the block must stall its input
   task automatic test_output_backpressure();
      configure(8, 4, K_SMALL);
      hold_request = HOLD_CYCLES;
      send_frame(8 * 4, 9, 0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int unsigned     w, h, wreg, hreg, total, flushes, frames, f, pick, cut;
      int unsigned     phase, phase_end;
      kernel_kind_type kind;
      for (phase = 0; phase < IDLE_PHASES; phase++) begin
         set_idling(phase);
         phase_end = random_items + RANDOM_ITEMS / IDLE_PHASES;
         while (random_items < phase_end) begin
            w = $urandom_range(MIN_WIDTH, 12);
            h = $urandom_range(MIN_HEIGHT, 6);
            if ($urandom_range(9) == 0) begin
               w = $urandom_range(13, 64);
               h = MIN_HEIGHT;
            end
            wreg = w;
            hreg = h;
            if (w == MIN_WIDTH && $urandom_range(1)) wreg = $urandom_range(MIN_WIDTH - 1);
            if (h == MIN_HEIGHT && $urandom_range(1)) hreg = $urandom_range(MIN_HEIGHT - 1);
            kind = kernel_kind_type'($urandom_range(K_SOBEL));
            configure(wreg, hreg, kind);
            total = w * h;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
               if ($urandom_range(9) == 0) begin
                  // truncated frame; the next size write restarts it
                  cut = $urandom_range(1, total - 1);
                  send_frame(cut, 0, NOISE_PCT);
                  random_items += cut;
                  break;
               end
               pick = $urandom_range(9);
               case (pick)
                  0: flushes = $urandom_range(w);
                  1: flushes = w + 1 + $urandom_range(1, 3);
                  default: flushes = w + 1;
               endcase
               send_frame(total, flushes, NOISE_PCT);
               random_items += total + ((flushes > w + 1) ? w + 1 : flushes);
            end
            wait_drained();
         end
      end
      set_idling(0);
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_PIXEL;
      req_ch.blue_in  = '0;
      req_ch.green_in = '0;
      req_ch.red_in   = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_IMAGE_WIDTH;
      csr_ch.data     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_small_frames();
      test_wide_frame();
      test_tall_frame();
      test_output_backpressure();
      test_random_frames();
      wait_drained();

      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/rcs_pkg.sv
sv/rcs_if.sv
sv/rcs_line_delay.sv
sv/rcs_row_cell.sv
sv/rgb_conv3x3_stream.sv
tb/sv/tb.sv
